// ===== rtl/cbx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the coil bank with expander update.
// Used by every module of the block; depends on nothing else.

package cbx_pkg;

  // Bank and expander geometry.
  localparam int NUM_COILS = 64;
  localparam int NUM_CHIPS = 4;
  localparam int CHIP_W    = 2;
  localparam int LATCH_W   = 16;

  // Request operation codes.
  localparam logic [1:0] OP_READ         = 2'd0;
  localparam logic [1:0] OP_WRITE_SINGLE = 2'd1;
  localparam logic [1:0] OP_WRITE_MULTI  = 2'd2;

  // Result item kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_LATCH  = 1'b1;

  // Status codes.
  localparam logic STAT_OK           = 1'b0;
  localparam logic STAT_ILLEGAL_ADDR = 1'b1;

  // Outcome of executing one request against the coil bank.
  typedef struct packed {
    logic                 refresh;     // a write was accepted, latches need remapping
    logic                 status;
    logic [NUM_COILS-1:0] read_data;
    logic [NUM_COILS-1:0] coils_next;
  } exec_res_t;

  // Work handed to the result emitter for one request.
  typedef struct packed {
    logic [NUM_CHIPS-1:0] changed;     // chips whose latch changed
    logic                 status;
    logic [NUM_COILS-1:0] read_data;
  } emit_job_t;

endpackage

// ===== rtl/coil_bank_with_expander_update.sv =====
`timescale 1ns / 1ps
// Top level of the coil bank with expander latch update.
// Depends on cbx_pkg, cbx_req_exec, cbx_latch_map and cbx_emitter.

// A request beat is captured in an input register and executed
// combinationally against the 64-coil bank; any accepted write remaps the
// coils onto the four expander latches in the same cycle. The results
// then leave one beat per cycle while rsp_stall is low: a latch beat for
// each chip whose latch changed, in chip order, then the status beat with
// last set. The next request is executed as soon as the previous one's
// status beat has been loaded into the output register, and the input
// register holds one request meanwhile.

module coil_bank_with_expander_update (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    operation,
  input  logic [15:0]                   address,
  input  logic [15:0]                   count,
  input  logic [15:0]                   single_value,
  input  logic [cbx_pkg::NUM_COILS-1:0] write_data,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          item_kind,
  output logic                          status,
  output logic [cbx_pkg::NUM_COILS-1:0] read_data,
  output logic [cbx_pkg::CHIP_W-1:0]    chip_index,
  output logic [7:0]                    port_a_value,
  output logic [7:0]                    port_b_value,
  output logic                          last
);

  logic                          req_held;
  logic [1:0]                    op_q;
  logic [15:0]                   addr_q;
  logic [15:0]                   cnt_q;
  logic [15:0]                   sval_q;
  logic [cbx_pkg::NUM_COILS-1:0] wdata_q;

  logic [cbx_pkg::NUM_COILS-1:0] coil_bits;
  logic [cbx_pkg::LATCH_W-1:0]   latch_shadow [cbx_pkg::NUM_CHIPS];
  logic [cbx_pkg::LATCH_W-1:0]   latch_next   [cbx_pkg::NUM_CHIPS];

  cbx_pkg::exec_res_t            exec_res;
  cbx_pkg::emit_job_t            job;
  logic                          emit_idle;
  logic                          launch;
  logic                          req_take;

  // Input register: holds one request until the emitter is free.
  assign launch    = req_held && emit_idle;
  assign req_stall = req_held && !launch;
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_held <= 1'b0;
    end else begin
      req_held <= req_take || (req_held && !launch);
    end
    if (req_take) begin
      op_q    <= operation;
      addr_q  <= address;
      cnt_q   <= count;
      sval_q  <= single_value;
      wdata_q <= write_data;
    end
  end

  // Execute the held request.
  cbx_req_exec u_exec (
    .operation    (op_q),
    .address      (addr_q),
    .count        (cnt_q),
    .single_value (sval_q),
    .write_data   (wdata_q),
    .coil_bits    (coil_bits),
    .res          (exec_res)
  );

  // Remap the updated coils onto the expander latches.
  cbx_latch_map u_map (
    .coils      (exec_res.coils_next),
    .latch_next (latch_next)
  );

  // Build the emitter job: a chip is reported only after a write.
  always_comb begin
    job.status    = exec_res.status;
    job.read_data = exec_res.read_data;
    for (int c = 0; c < cbx_pkg::NUM_CHIPS; c++) begin
      job.changed[c] = exec_res.refresh && (latch_next[c] != latch_shadow[c]);
    end
  end

  // Coil bank and latch shadows update when a request with an accepted write launches.
  always_ff @(posedge clk) begin
    if (rst) begin
      coil_bits <= '0;
      for (int c = 0; c < cbx_pkg::NUM_CHIPS; c++) begin
        latch_shadow[c] <= '0;
      end
    end else if (launch && exec_res.refresh) begin
      coil_bits <= exec_res.coils_next;
      for (int c = 0; c < cbx_pkg::NUM_CHIPS; c++) begin
        latch_shadow[c] <= latch_next[c];
      end
    end
  end

  cbx_emitter u_emit (
    .clk          (clk),
    .rst          (rst),
    .launch       (launch),
    .job          (job),
    .latch        (latch_shadow),
    .idle         (emit_idle),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .item_kind    (item_kind),
    .status       (status),
    .read_data    (read_data),
    .chip_index   (chip_index),
    .port_a_value (port_a_value),
    .port_b_value (port_b_value),
    .last         (last)
  );

  // A rejected or read request leaves the coil bank untouched.
  a_no_write_keeps_coils: assert property (
    @(posedge clk) disable iff (rst)
    launch && !exec_res.refresh |=> coil_bits == $past(coil_bits)
  ) else $error("coil bank changed without an accepted write");

  // A latch beat carries exactly the shadow value of its chip.
  a_latch_matches_shadow: assert property (
    @(posedge clk) disable iff (rst)
    rsp_valid && item_kind == cbx_pkg::KIND_LATCH |->
      {port_a_value, port_b_value} == latch_shadow[chip_index]
  ) else $error("latch beat does not match shadow register");

  // Latch beats are never final and always carry success.
  a_latch_not_last: assert property (
    @(posedge clk) disable iff (rst)
    rsp_valid && item_kind == cbx_pkg::KIND_LATCH |->
      !last && status == cbx_pkg::STAT_OK
  ) else $error("latch beat marked last or failing");

  // A failed request never reports latch changes.
  a_fail_no_latch: assert property (
    @(posedge clk) disable iff (rst)
    launch && exec_res.status == cbx_pkg::STAT_ILLEGAL_ADDR |-> job.changed == '0
  ) else $error("rejected request produced latch work");

endmodule

// ===== rtl/cbx_req_exec.sv =====
`timescale 1ns / 1ps
// Request execution: range check, coil read and coil update for one request.
// Depends on cbx_pkg.

module cbx_req_exec (
  input  logic [1:0]                     operation,
  input  logic [15:0]                    address,
  input  logic [15:0]                    count,
  input  logic [15:0]                    single_value,
  input  logic [cbx_pkg::NUM_COILS-1:0]  write_data,
  input  logic [cbx_pkg::NUM_COILS-1:0]  coil_bits,
  output cbx_pkg::exec_res_t             res
);

  logic [16:0]                   span;
  logic                          range_ok;
  logic                          single_ok;
  logic [5:0]                    shamt;
  logic [cbx_pkg::NUM_COILS-1:0] cnt_mask;
  logic [cbx_pkg::NUM_COILS-1:0] bit_sel;

  // Range checks; the sum is formed one bit wider so it cannot wrap.
  assign span      = {1'b0, address} + {1'b0, count};
  assign range_ok  = (span <= 17'd64);
  assign single_ok = (address < 16'd64);
  assign shamt     = address[5:0];

  // Mask of count ones; only used when the range check passed (count <= 64).
  assign cnt_mask = count[6] ? {cbx_pkg::NUM_COILS{1'b1}}
                             : ((64'd1 << count[5:0]) - 64'd1);
  assign bit_sel  = 64'd1 << shamt;

  // Decode the operation. A zero count gives a zero mask, so a read
  // returns zero and a multiple write leaves every coil alone.
  always_comb begin
    res.refresh    = 1'b0;
    res.status     = cbx_pkg::STAT_ILLEGAL_ADDR;
    res.read_data  = '0;
    res.coils_next = coil_bits;
    case (operation)
      cbx_pkg::OP_READ: begin
        if (range_ok) begin
          res.status    = cbx_pkg::STAT_OK;
          res.read_data = (coil_bits >> shamt) & cnt_mask;
        end
      end
      cbx_pkg::OP_WRITE_SINGLE: begin
        if (single_ok) begin
          res.status  = cbx_pkg::STAT_OK;
          res.refresh = 1'b1;
          if (single_value != 16'd0) begin
            res.coils_next = coil_bits | bit_sel;
          end else begin
            res.coils_next = coil_bits & ~bit_sel;
          end
        end
      end
      cbx_pkg::OP_WRITE_MULTI: begin
        if (range_ok) begin
          res.status     = cbx_pkg::STAT_OK;
          res.refresh    = 1'b1;
          res.coils_next = (coil_bits & ~(cnt_mask << shamt)) |
                           ((write_data & cnt_mask) << shamt);
        end
      end
      default: begin
        // Unused operation code: rejected as an illegal address.
        res.status = cbx_pkg::STAT_ILLEGAL_ADDR;
      end
    endcase
  end

endmodule

// ===== rtl/cbx_latch_map.sv =====
`timescale 1ns / 1ps
// Fixed channel map from the 64 coils onto the four 16-bit expander latches.
// Depends on cbx_pkg. Latch layout: port A in bits 15..8, port B in bits 7..0.

module cbx_latch_map (
  input  logic [cbx_pkg::NUM_COILS-1:0] coils,
  output logic [cbx_pkg::LATCH_W-1:0]   latch_next [cbx_pkg::NUM_CHIPS]
);

  // Chips 0,1: each byte bit-reversed; chips 2,3: bytes swapped, bits kept.
  for (genvar c = 0; c < cbx_pkg::NUM_CHIPS; c++) begin : g_chip
    logic [15:0] grp;
    logic [7:0]  port_a;
    logic [7:0]  port_b;

    assign grp = coils[c*16 +: 16];

    always_comb begin
      for (int j = 0; j < 8; j++) begin
        if (c < 2) begin
          port_b[j] = grp[7 - j];
          port_a[j] = grp[15 - j];
        end else begin
          port_a[j] = grp[j];
          port_b[j] = grp[8 + j];
        end
      end
    end

    assign latch_next[c] = {port_a, port_b};
  end

endmodule

// ===== rtl/cbx_emitter.sv =====
`timescale 1ns / 1ps
// Result emitter: sends one latch beat per changed chip, then the status beat.
// Depends on cbx_pkg; reads latch values from the shadow registers of the top.

module cbx_emitter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          launch,
  input  cbx_pkg::emit_job_t            job,
  input  logic [cbx_pkg::LATCH_W-1:0]   latch [cbx_pkg::NUM_CHIPS],
  output logic                          idle,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          item_kind,
  output logic                          status,
  output logic [cbx_pkg::NUM_COILS-1:0] read_data,
  output logic [cbx_pkg::CHIP_W-1:0]    chip_index,
  output logic [7:0]                    port_a_value,
  output logic [7:0]                    port_b_value,
  output logic                          last
);

  logic [cbx_pkg::NUM_CHIPS-1:0] pend;
  logic                          stat_pend;
  logic                          job_status;
  logic [cbx_pkg::NUM_COILS-1:0] job_rdata;
  logic                          out_load;
  logic [cbx_pkg::CHIP_W-1:0]    first_chip;

  assign idle     = (pend == '0) && !stat_pend;
  assign out_load = !rsp_valid || !rsp_stall;

  // Lowest pending chip goes out first.
  always_comb begin
    first_chip = '0;
    for (int i = cbx_pkg::NUM_CHIPS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        first_chip = i[cbx_pkg::CHIP_W-1:0];
      end
    end
  end

  // Pending work and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      stat_pend <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (out_load) begin
        if (pend != '0) begin
          rsp_valid    <= 1'b1;
          item_kind    <= cbx_pkg::KIND_LATCH;
          status       <= cbx_pkg::STAT_OK;
          read_data    <= '0;
          chip_index   <= first_chip;
          port_a_value <= latch[first_chip][15:8];
          port_b_value <= latch[first_chip][7:0];
          last         <= 1'b0;
          pend[first_chip] <= 1'b0;
        end else if (stat_pend) begin
          rsp_valid    <= 1'b1;
          item_kind    <= cbx_pkg::KIND_STATUS;
          status       <= job_status;
          read_data    <= job_rdata;
          chip_index   <= '0;
          port_a_value <= '0;
          port_b_value <= '0;
          last         <= 1'b1;
          stat_pend    <= 1'b0;
        end else begin
          rsp_valid <= 1'b0;
        end
      end
      // A new job is taken only while nothing is pending.
      if (launch) begin
        pend       <= job.changed;
        stat_pend  <= 1'b1;
        job_status <= job.status;
        job_rdata  <= job.read_data;
      end
    end
  end

endmodule
